// ----- rtl/vt4_pkg.sv -----
// shared types and constants for the 4x4 vertex transform
package vt4_pkg;

  localparam int COEF_WIDTH_DEF  = 16;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int LANE_STRIDE     = 16;
  localparam int COEF_FRAC       = 12;
  localparam int COORD_FRAC      = 16;
  localparam int NUM_ROWS        = 4;
  localparam int FIELD_W         = 32;
  localparam int REG_W           = 64;
  localparam int IDX_W           = 3;
  localparam int IP_BITS         = COORD_FRAC + 1;
  localparam int QUO_BITS        = 2 * IP_BITS;
  localparam int MAG_BITS        = 41;
  localparam int ROUND_HALF      = 1 << (COEF_FRAC - 1);

  localparam logic [REG_W-1:0] ROW_RESET [NUM_ROWS] = '{
    64'h0000_0000_0000_1000,
    64'h0000_0000_1000_0000,
    64'h0000_1000_0000_0000,
    64'h1000_0000_0000_0000
  };

  typedef enum logic [1:0] {
    ACT_PROJ    = 2'd0,
    ACT_AFFINE  = 2'd1,
    ACT_DIR     = 2'd2,
    ACT_DIR_ALT = 2'd3
  } action_t;

  typedef struct packed {
    action_t            action;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               w_zero;
    logic               saturated;
  } out_t;

endpackage

// ----- rtl/vt4_div.sv -----
// pipelined restoring divider, one quotient bit per stage
module vt4_div #(
  parameter int AW = 50
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic [AW-1:0]                  an,
  input  logic [AW-1:0]                  ad,
  output logic [vt4_pkg::QUO_BITS-1:0]   q
);
  import vt4_pkg::*;

  logic [AW-1:0]       rem_s [QUO_BITS];
  logic [QUO_BITS-1:0] lo_s  [QUO_BITS];
  logic [AW-1:0]       ad_s  [QUO_BITS];
  logic [QUO_BITS-1:0] q_s   [QUO_BITS+1];

  assign rem_s[0] = an >> IP_BITS;
  assign lo_s[0]  = {an[IP_BITS-1:0], {IP_BITS{1'b0}}};
  assign ad_s[0]  = ad;
  assign q_s[0]   = '0;

  for (genvar k = 0; k < QUO_BITS; k++) begin : g_step
    logic [AW:0] t;
    logic        ge;
    assign t  = {rem_s[k], lo_s[k][QUO_BITS-1]};
    assign ge = t >= {1'b0, ad_s[k]};

    logic [QUO_BITS-1:0] q_nxt;
    logic [QUO_BITS-1:0] q_r;
    assign q_nxt = {q_s[k][QUO_BITS-2:0], ge};
    always_ff @(posedge clk) begin
      if (en) begin
        q_r <= q_nxt;
      end
    end
    assign q_s[k+1] = q_r;

    if (k < QUO_BITS - 1) begin : g_carry
      logic [AW-1:0]       rem_nxt;
      logic [AW-1:0]       rem_r;
      logic [QUO_BITS-1:0] lo_r;
      logic [AW-1:0]       ad_r;
      assign rem_nxt = ge ? AW'(t - {1'b0, ad_s[k]}) : AW'(t);
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r <= rem_nxt;
          lo_r  <= {lo_s[k][QUO_BITS-2:0], 1'b0};
          ad_r  <= ad_s[k];
        end
      end
      assign rem_s[k+1] = rem_r;
      assign lo_s[k+1]  = lo_r;
      assign ad_s[k+1]  = ad_r;
    end
  end

  assign q = q_s[QUO_BITS];

endmodule

// ----- rtl/vertex_transform_4x4.sv -----
// top level: 4x4 homogeneous vertex transform with perspective divide
// pipeline: 4 arithmetic stages, 34 divider stages, rounding and output register
// throughput: one item per cycle; the whole pipeline holds while a result waits
// reset: synchronous active-low, clears valid bits and loads the identity matrix
module vertex_transform_4x4 #(
  parameter int COEF_WIDTH  = vt4_pkg::COEF_WIDTH_DEF,
  parameter int COORD_WIDTH = vt4_pkg::COORD_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  vt4_pkg::in_t                in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output vt4_pkg::out_t               out_data,
  input  logic                        cfg_we,
  input  logic [vt4_pkg::IDX_W-1:0]   cfg_index,
  input  logic [vt4_pkg::REG_W-1:0]   cfg_wdata
);
  import vt4_pkg::*;

  localparam int PW  = COEF_WIDTH + COORD_WIDTH;
  localparam int SW  = PW + 2;
  localparam int VW  = SW - COEF_FRAC;
  localparam int LAT = QUO_BITS + 6;
  localparam longint HI_L = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
  localparam logic signed [VW-1:0] HI_V = VW'(HI_L);
  localparam logic signed [VW-1:0] LO_V = VW'(-HI_L - 64'sd1);
  localparam logic [MAG_BITS-1:0] NEG_LIM = MAG_BITS'(64'd1 << (COORD_WIDTH - 1));
  localparam logic [MAG_BITS-1:0] POS_LIM = NEG_LIM - MAG_BITS'(1);
  localparam logic [MAG_BITS-1:0] OVF_MAG = MAG_BITS'(64'd1 << (MAG_BITS - 1));

  typedef struct packed {
    logic                  proj;
    logic                  wz;
    logic [3:0]            neg;
    logic [2:0]            ovf;
    logic [2:0][31:0]      aff;
    logic                  aff_sat;
  } side_t;

  logic en;
  logic vld_r [LAT];

  assign en        = !vld_r[LAT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int k = 1; k < LAT; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  // matrix rows
  logic [REG_W-1:0] row_r [NUM_ROWS];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < NUM_ROWS; r++) row_r[r] <= ROW_RESET[r];
    end else if (cfg_we && cfg_index < IDX_W'(NUM_ROWS)) begin
      row_r[cfg_index[1:0]] <= cfg_wdata;
    end
  end

  // stage 1: products
  logic signed [COEF_WIDTH-1:0]             cf [4][4];
  logic signed [COORD_WIDTH-1:0]            pt [3];
  logic signed [COEF_WIDTH+COORD_FRAC-1:0]  tr [4];
  logic signed [PW-1:0] prod_nxt [4][4];
  logic signed [PW-1:0] prod_r   [4][4];
  logic                 use_t;
  action_t              act1_r;

  assign pt[0] = in_data.in_x[COORD_WIDTH-1:0];
  assign pt[1] = in_data.in_y[COORD_WIDTH-1:0];
  assign pt[2] = in_data.in_z[COORD_WIDTH-1:0];
  assign use_t = (in_data.action == ACT_PROJ) || (in_data.action == ACT_AFFINE);

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) cf[r][c] = row_r[r][LANE_STRIDE*c +: COEF_WIDTH];
      tr[r] = {cf[r][3], {COORD_FRAC{1'b0}}};
      for (int c = 0; c < 3; c++) prod_nxt[r][c] = cf[r][c] * pt[c];
      prod_nxt[r][3] = use_t ? PW'(tr[r]) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      act1_r <= in_data.action;
    end
  end

  // stage 2: row sums
  logic signed [SW-1:0] sum_r [4];
  logic                 proj2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        sum_r[r] <= SW'(prod_r[r][0]) + SW'(prod_r[r][1]) + SW'(prod_r[r][2])
                  + SW'(prod_r[r][3]);
      end
      proj2_r <= act1_r == ACT_PROJ;
    end
  end

  // stage 3: magnitudes and fixed-point rounding
  logic [SW-1:0]        mag3_r [4];
  logic [3:0]           neg3_r;
  logic                 wz3_r;
  logic                 proj3_r;
  logic signed [VW-1:0] v3_r [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        neg3_r[r] <= sum_r[r][SW-1];
        mag3_r[r] <= sum_r[r][SW-1] ? SW'(-sum_r[r]) : SW'(sum_r[r]);
      end
      for (int r = 0; r < 3; r++) begin
        v3_r[r] <= VW'((sum_r[r] + SW'(ROUND_HALF)) >>> COEF_FRAC);
      end
      wz3_r   <= sum_r[3] == '0;
      proj3_r <= proj2_r;
    end
  end

  // stage 4: divide overflow check and clamp of non-projective results
  logic [SW-1:0]  an_r [3];
  logic [SW-1:0]  ad_r;
  side_t          side_nxt;
  side_t          side_r [QUO_BITS+1];

  always_comb begin
    side_nxt.proj    = proj3_r;
    side_nxt.wz      = wz3_r;
    side_nxt.neg     = neg3_r;
    side_nxt.aff_sat = 1'b0;
    for (int r = 0; r < 3; r++) begin
      side_nxt.ovf[r] = (mag3_r[r] >> IP_BITS) >= mag3_r[3];
      if (v3_r[r] > HI_V) begin
        side_nxt.aff[r]  = 32'(HI_V[COORD_WIDTH-1:0]);
        side_nxt.aff_sat = 1'b1;
      end else if (v3_r[r] < LO_V) begin
        side_nxt.aff[r]  = 32'(LO_V[COORD_WIDTH-1:0]);
        side_nxt.aff_sat = 1'b1;
      end else begin
        side_nxt.aff[r]  = 32'($signed(v3_r[r][COORD_WIDTH-1:0]));
      end
    end
    if (COORD_WIDTH < 32) begin
      for (int r = 0; r < 3; r++) begin
        if (side_nxt.aff[r][COORD_WIDTH-1]) begin
          side_nxt.aff[r] = side_nxt.aff[r] | ~(32'hFFFF_FFFF >> (32 - COORD_WIDTH));
        end else begin
          side_nxt.aff[r] = side_nxt.aff[r] & (32'hFFFF_FFFF >> (32 - COORD_WIDTH));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) an_r[r] <= mag3_r[r];
      ad_r      <= mag3_r[3];
      side_r[0] <= side_nxt;
    end
  end

  for (genvar k = 1; k <= QUO_BITS; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  logic [QUO_BITS-1:0] q [3];
  for (genvar r = 0; r < 3; r++) begin : g_div
    vt4_div #(.AW(SW)) u_div (
      .clk (clk),
      .en  (en),
      .an  (an_r[r]),
      .ad  (ad_r),
      .q   (q[r])
    );
  end

  // rounding stage
  logic [MAG_BITS-1:0] mag_rd_r [3];
  side_t               side_rd_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        mag_rd_r[r] <= side_r[QUO_BITS].ovf[r] ? OVF_MAG
                     : MAG_BITS'((({1'b0, q[r]}) + (QUO_BITS+1)'(1)) >> 1);
      end
      side_rd_r <= side_r[QUO_BITS];
    end
  end

  // output stage: clamp quotient and select by mode
  logic signed [COORD_WIDTH-1:0] dres [3];
  logic [2:0][31:0]              crd;
  logic                          dsat;
  logic                          neg_q;
  out_t                          out_nxt;
  out_t                          out_data_r;

  always_comb begin
    dsat = 1'b0;
    for (int r = 0; r < 3; r++) begin
      neg_q = side_rd_r.neg[r] ^ side_rd_r.neg[3];
      if (neg_q) begin
        if (mag_rd_r[r] > NEG_LIM) begin
          dres[r] = LO_V[COORD_WIDTH-1:0];
          dsat    = 1'b1;
        end else begin
          dres[r] = COORD_WIDTH'(-mag_rd_r[r]);
        end
      end else begin
        if (mag_rd_r[r] > POS_LIM) begin
          dres[r] = HI_V[COORD_WIDTH-1:0];
          dsat    = 1'b1;
        end else begin
          dres[r] = COORD_WIDTH'(mag_rd_r[r]);
        end
      end
    end
    if (side_rd_r.proj) begin
      for (int r = 0; r < 3; r++) crd[r] = side_rd_r.wz ? 32'd0 : 32'(dres[r]);
      out_nxt.w_zero    = side_rd_r.wz;
      out_nxt.saturated = side_rd_r.wz ? 1'b0 : dsat;
    end else begin
      crd               = side_rd_r.aff;
      out_nxt.w_zero    = 1'b0;
      out_nxt.saturated = side_rd_r.aff_sat;
    end
    out_nxt.out_x = crd[0];
    out_nxt.out_y = crd[1];
    out_nxt.out_z = crd[2];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_data = out_data_r;

endmodule

// ----- rtl/vt4_chk.sv -----
// port-level checker for the vertex transform, bound to the top level
module vt4_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input vt4_pkg::in_t                in_data,
  input logic                        out_valid,
  input logic                        out_ready,
  input vt4_pkg::out_t               out_data,
  input logic                        cfg_we,
  input logic [vt4_pkg::IDX_W-1:0]   cfg_index,
  input logic [vt4_pkg::REG_W-1:0]   cfg_wdata
);
  import vt4_pkg::*;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled item changed");

  a_wzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.w_zero |-> out_data.out_x == 32'd0 && out_data.out_y == 32'd0
      && out_data.out_z == 32'd0 && !out_data.saturated)
    else $error("zero w item not cleared");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");

endmodule

bind vertex_transform_4x4 vt4_chk u_vt4_chk (.*);
